// ===== hdl/sms_pkg.sv =====
// shared types and constants for the sorted multiset store
package sms_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [IDX_W-1:0]             idx_t;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_CONTAINS = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_DUMP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic  ins;
    logic  rot;
    data_t value;
  } chain_ctl_t;

endpackage

// ===== hdl/sms_cell.sv =====
// one storage cell of the sorted chain
module sms_cell (
  input  logic                clk,
  input  sms_pkg::chain_ctl_t ctl,
  input  logic                vld,
  input  logic                tail,
  input  logic                left_ge,
  input  sms_pkg::data_t      left_val,
  input  sms_pkg::data_t      right_val,
  input  sms_pkg::data_t      head_val,
  output sms_pkg::data_t      val,
  output logic                ge,
  output logic                eq
);

  // an empty cell counts as larger than anything
  assign ge = !vld || (ctl.value <= val);
  assign eq = vld && (val == ctl.value);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left_ge) begin
        val <= left_val;
      end else if (ge) begin
        val <= ctl.value;
      end
    end else if (ctl.rot && vld) begin
      val <= tail ? head_val : right_val;
    end
  end

endmodule

// ===== hdl/sms_ctrl.sv =====
// command sequencer, entry count and output register
module sms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          s_tuser,
  input  sms_pkg::data_t      s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output sms_pkg::data_t      m_tdata,
  output logic [2:0]          m_tuser,
  output logic                m_tlast,
  input  logic                hit,
  input  sms_pkg::data_t      head_val,
  output sms_pkg::chain_ctl_t ctl,
  output sms_pkg::cnt_t       count
);

  sms_pkg::state_e  state, state_next;
  sms_pkg::cnt_t    count_next;
  sms_pkg::idx_t    idx, idx_next;
  sms_pkg::cmd_e    cmd;
  sms_pkg::status_e o_status, status;
  sms_pkg::data_t   o_value;
  logic             o_found, o_last, found;
  logic             out_free, accept, load, dump_last, full;

  assign cmd       = sms_pkg::cmd_e'(s_tuser);
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == sms_pkg::S_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign full      = (count == sms_pkg::cnt_t'(sms_pkg::DEPTH));
  assign dump_last = ((sms_pkg::cnt_t'(idx) + sms_pkg::cnt_t'(1)) == count);

  always_comb begin
    state_next = state;
    case (state)
      sms_pkg::S_IDLE: begin
        if (accept && (cmd == sms_pkg::CMD_DUMP) && (count != '0)) begin
          state_next = sms_pkg::S_DUMP;
        end
      end
      sms_pkg::S_DUMP: begin
        if (out_free && dump_last) begin
          state_next = sms_pkg::S_IDLE;
        end
      end
      default: state_next = sms_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    load       = 1'b0;
    o_value    = '0;
    o_found    = 1'b0;
    o_status   = sms_pkg::ST_OK;
    o_last     = 1'b1;
    ctl.ins    = 1'b0;
    ctl.rot    = 1'b0;
    ctl.value  = s_tdata;
    count_next = count;
    idx_next   = idx;
    case (state)
      sms_pkg::S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (cmd)
            sms_pkg::CMD_INSERT: begin
              if (full) begin
                o_status = sms_pkg::ST_FULL;
              end else begin
                ctl.ins    = 1'b1;
                count_next = count + sms_pkg::cnt_t'(1);
              end
            end
            sms_pkg::CMD_CONTAINS: o_found = hit;
            sms_pkg::CMD_CLEAR:    count_next = '0;
            sms_pkg::CMD_DUMP: begin
              if (count == '0) begin
                o_status = sms_pkg::ST_EMPTY;
              end else begin
                // no beat for the command itself; the entries go out from the dump state
                load     = 1'b0;
                idx_next = '0;
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      sms_pkg::S_DUMP: begin
        if (out_free) begin
          load     = 1'b1;
          o_value  = head_val;
          o_last   = dump_last;
          ctl.rot  = 1'b1;
          idx_next = idx + sms_pkg::idx_t'(1);
        end
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sms_pkg::S_IDLE;
      count    <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= o_value;
      found   <= o_found;
      status  <= o_status;
      m_tlast <= o_last;
    end
  end

  assign m_tuser = {status, found};

endmodule

// ===== hdl/sorted_multiset_store.sv =====
// top level of the sorted multiset store: cell chain plus sequencer
//
// Keeps up to DEPTH (16) signed 32-bit values in ascending order in a row of
// cells. Insert, contains and clear are each one input beat and one result
// beat; every cell compares its entry with the broadcast value at once, so an
// insert shifts the larger entries one cell right in a single step. Dump of
// n stored entries gives n result beats, one per cycle while the output
// register is free, read at cell 0 while the occupied part of the chain
// rotates one place left; after n steps the original order is back. A dump
// of an empty store gives one beat with status 2. The input takes no new
// beat while a dump runs or while the output register holds a beat that is
// not taken. A full store drops an insert and answers status 1. Entries have
// no reset; the entry count is cleared by reset, so no clearing pass is
// needed.
module sorted_multiset_store (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  sms_pkg::data_t        s_tdata,  // item_value
  input  logic [1:0]            s_tuser,  // command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output sms_pkg::data_t        m_tdata,  // out_value
  output logic [2:0]            m_tuser,  // {status[1:0], found}
  output logic                  m_tlast   // is_last
);

  sms_pkg::chain_ctl_t          ctl;
  sms_pkg::cnt_t                count;
  sms_pkg::data_t               cell_val [sms_pkg::DEPTH];
  logic [sms_pkg::DEPTH-1:0]    cell_vld;
  logic [sms_pkg::DEPTH-1:0]    cell_tail;
  logic [sms_pkg::DEPTH-1:0]    cell_ge;
  logic [sms_pkg::DEPTH-1:0]    cell_eq;
  logic                         hit;

  // contains: any occupied cell holding an equal value
  assign hit = |cell_eq;

  for (genvar i = 0; i < sms_pkg::DEPTH; i++) begin : g_chain
    // occupancy is a thermometer of the entry count
    assign cell_vld[i] = (sms_pkg::cnt_t'(i) < count);

    if (i == sms_pkg::DEPTH - 1) begin : g_end
      assign cell_tail[i] = cell_vld[i];
    end else begin : g_mid
      assign cell_tail[i] = cell_vld[i] && !cell_vld[i+1];
    end

    if (i == 0) begin : g_first
      sms_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .vld       (cell_vld[i]),
        .tail      (cell_tail[i]),
        .left_ge   (1'b0),
        .left_val  (ctl.value),
        .right_val (cell_val[i+1]),
        .head_val  (cell_val[0]),
        .val       (cell_val[i]),
        .ge        (cell_ge[i]),
        .eq        (cell_eq[i])
      );
    end else if (i == sms_pkg::DEPTH - 1) begin : g_last
      sms_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .vld       (cell_vld[i]),
        .tail      (cell_tail[i]),
        .left_ge   (cell_ge[i-1]),
        .left_val  (cell_val[i-1]),
        .right_val (cell_val[0]),
        .head_val  (cell_val[0]),
        .val       (cell_val[i]),
        .ge        (cell_ge[i]),
        .eq        (cell_eq[i])
      );
    end else begin : g_inner
      sms_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .vld       (cell_vld[i]),
        .tail      (cell_tail[i]),
        .left_ge   (cell_ge[i-1]),
        .left_val  (cell_val[i-1]),
        .right_val (cell_val[i+1]),
        .head_val  (cell_val[0]),
        .val       (cell_val[i]),
        .ge        (cell_ge[i]),
        .eq        (cell_eq[i])
      );
    end
  end

  sms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .hit      (hit),
    .head_val (cell_val[0]),
    .ctl      (ctl),
    .count    (count)
  );

  // entry count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sms_pkg::cnt_t'(sms_pkg::DEPTH))
    else $error("entry count above capacity");

  // the chain never shifts for an insert and rotates for a dump at once
  a_ins_rot: assert property (@(posedge clk) disable iff (rst)
    !(ctl.ins && ctl.rot))
    else $error("insert and rotate together");

  // an insert that goes in grows the count by exactly one
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> (count == $past(count) + sms_pkg::cnt_t'(1)))
    else $error("insert did not bump count");

  // no input beat is taken while the chain rotates for a dump
  a_rot_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.rot |-> !s_tready)
    else $error("input ready during dump");

endmodule
